// File: sv/ssls_pkg.sv
// ----------------------------------------------------------------------------
// ssls_pkg
// Types and constants shared by the servo slew limiter modules.
// ----------------------------------------------------------------------------
package ssls_pkg;

  // input beat
  typedef struct packed {
    logic        func;
    logic [15:0] target;
    logic [31:0] now_ms;
  } ssls_in_t;

  // result beat
  typedef struct packed {
    logic [15:0] pulse_width;
    logic        reached;
    logic        error;
  } ssls_out_t;

  // configuration registers
  typedef struct packed {
    logic [15:0] pos_min;
    logic [15:0] pos_max;
    logic [15:0] step_size;
    logic [15:0] step_interval_ms;
  } ssls_cfg_t;

  // architectural state carried from one call to the next
  typedef struct packed {
    logic [15:0] position;
    logic [31:0] last_move_ms;
    logic        sweep_up;
    logic        reached_flag;
    logic [15:0] sweep_point;
  } ssls_state_t;

  // mode codes
  localparam logic FUNC_SET   = 1'b0;
  localparam logic FUNC_SWEEP = 1'b1;

  // register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_POS_MIN       = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_POS_MAX       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEP_SIZE     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_STEP_INTERVAL = 2'd3;

  // reset values
  localparam logic [15:0] POS_MIN_RST       = 16'd1000;
  localparam logic [15:0] POS_MAX_RST       = 16'd2000;
  localparam logic [15:0] STEP_SIZE_RST     = 16'd20;
  localparam logic [15:0] STEP_INTERVAL_RST = 16'd20;
  localparam logic [15:0] POSITION_RST      = 16'd1500;
  localparam logic [15:0] SWEEP_POINT_RST   = 16'd1000;

endpackage

// File: sv/servo_slew_limiter_with_sweep.sv
// ----------------------------------------------------------------------------
// servo_slew_limiter_with_sweep
// Servo pulse-width slew limiter with an automatic sweep mode.
// ----------------------------------------------------------------------------
// Each input beat is one call: either a requested target pulse width or a
// sweep step, together with the current millisecond tick. A beat is held in
// an input register, evaluated by the step logic against the live state and
// written to the result register, so one call is taken every clock while the
// result channel does not stall, and the result is on the outputs once the
// input register has passed it into the result register. State is updated at
// the same edge the result is registered, so back-to-back calls always see the
// outcome of the call before. The result register frees itself as soon as its
// beat is taken; while it is stalled the input register holds one more beat
// and the input stalls after that. Configuration writes are expected only
// while no call is in flight.
// ----------------------------------------------------------------------------
module servo_slew_limiter_with_sweep (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  ssls_pkg::ssls_in_t                   in_data,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output ssls_pkg::ssls_out_t                  out_data,
  // configuration port
  input  logic                                 cfg_we,
  input  logic [ssls_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [15:0]                          cfg_data
);
  import ssls_pkg::*;

  // configuration registers
  ssls_cfg_t   cfg_r;

  // architectural state
  ssls_state_t state_r;
  ssls_state_t state_nxt;

  // input register
  logic        s1_valid_r;
  ssls_in_t    s1_data_r;

  // result register
  logic        out_valid_r;
  ssls_out_t   out_data_r;
  ssls_out_t   result_nxt;

  logic        out_free;
  logic        s1_fire;
  logic        in_fire;

  // result slot can take a new beat when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  // input register frees when empty or moving on
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one call worth of logic
  ssls_step u_step (
    .cfg       (cfg_r),
    .state_cur (state_r),
    .item      (s1_data_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_min          <= POS_MIN_RST;
      cfg_r.pos_max          <= POS_MAX_RST;
      cfg_r.step_size        <= STEP_SIZE_RST;
      cfg_r.step_interval_ms <= STEP_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POS_MIN:       cfg_r.pos_min          <= cfg_data;
        CFG_POS_MAX:       cfg_r.pos_max          <= cfg_data;
        CFG_STEP_SIZE:     cfg_r.step_size        <= cfg_data;
        CFG_STEP_INTERVAL: cfg_r.step_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // state commits when a call passes into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.position     <= POSITION_RST;
      state_r.last_move_ms <= 32'd0;
      state_r.sweep_up     <= 1'b1;
      state_r.reached_flag <= 1'b0;
      state_r.sweep_point  <= SWEEP_POINT_RST;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= result_nxt;
    end
  end

endmodule

// File: sv/ssls_step.sv
// ----------------------------------------------------------------------------
// ssls_step
// Next-state and result logic for one call: sweep advance, range check,
// slew-limited move.
// ----------------------------------------------------------------------------
module ssls_step (
  input  ssls_pkg::ssls_cfg_t   cfg,
  input  ssls_pkg::ssls_state_t state_cur,
  input  ssls_pkg::ssls_in_t    item,
  output ssls_pkg::ssls_state_t state_nxt,
  output ssls_pkg::ssls_out_t   result
);
  import ssls_pkg::*;

  logic [16:0] sweep_sum;
  logic [15:0] sweep_pt;
  logic        sweep_dir;
  logic [15:0] tgt;
  logic        err;
  logic [31:0] elapsed;
  logic        due;
  logic [15:0] gap;
  logic [15:0] delta;
  logic        going_down;

  // sweep point advance, only on a sweep call when the previous call found the target reached
  always_comb begin
    sweep_sum = {1'b0, state_cur.sweep_point} + {1'b0, cfg.step_size};
    sweep_pt  = state_cur.sweep_point;
    sweep_dir = state_cur.sweep_up;
    if (item.func == FUNC_SWEEP && state_cur.reached_flag) begin
      if (state_cur.sweep_up) begin
        sweep_pt = sweep_sum[16] ? 16'hFFFF : sweep_sum[15:0];
        if (sweep_pt >= cfg.pos_max) sweep_dir = 1'b0;
      end else begin
        sweep_pt = (state_cur.sweep_point > cfg.step_size) ?
                   (state_cur.sweep_point - cfg.step_size) : 16'd0;
        if (sweep_pt <= cfg.pos_min) sweep_dir = 1'b1;
      end
    end
  end

  assign tgt        = (item.func == FUNC_SWEEP) ? sweep_pt : item.target;
  assign err        = (tgt < cfg.pos_min) || (tgt > cfg.pos_max);
  assign elapsed    = item.now_ms - state_cur.last_move_ms;
  assign due        = elapsed > {16'd0, cfg.step_interval_ms};
  assign going_down = state_cur.position > tgt;
  assign gap        = going_down ? (state_cur.position - tgt) : (tgt - state_cur.position);
  assign delta      = (gap > cfg.step_size) ? cfg.step_size : gap;

  always_comb begin
    state_nxt             = state_cur;
    state_nxt.sweep_point = sweep_pt;
    state_nxt.sweep_up    = sweep_dir;
    if (!err) begin
      if (state_cur.position == tgt) begin
        state_nxt.reached_flag = 1'b1;
      end else begin
        state_nxt.reached_flag = 1'b0;
        if (due) begin
          state_nxt.last_move_ms = item.now_ms;
          state_nxt.position     = going_down ? (state_cur.position - delta) :
                                                (state_cur.position + delta);
        end
      end
    end
  end

  always_comb begin
    result.pulse_width = state_nxt.position;
    result.reached     = state_nxt.reached_flag;
    result.error       = err;
  end

endmodule
